// ----- hw/rtl/rsc_pkg.sv -----
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types, constants and mod-26 helpers for the rotor substitution cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package rsc_pkg;

    // defaults for the top level parameters
    localparam int MAX_MODULES_DEF = 8;
    localparam int PERIOD_BITS_DEF = 16;

    // alphabet
    localparam logic [4:0] ALPHA  = 5'd26;
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_Z = 8'h5A;

    // item commands
    typedef enum logic [1:0] {
        CMD_KEY   = 2'd0,
        CMD_SET   = 2'd1,
        CMD_START = 2'd2,
        CMD_CHAR  = 2'd3
    } t_cmd;

    // configuration register indexes
    localparam logic CFG_ACTIVE = 1'b0;
    localparam logic CFG_REFL   = 1'b1;

    // key table write from a load item
    typedef struct packed {
        logic       valid;
        logic [2:0] sel;
        logic [4:0] plain;
        logic [4:0] key;
    } t_key_wr;

    // one lookup issued by the sequencer
    typedef struct packed {
        logic       issue;
        logic       inv;
        logic       first;
        logic [4:0] x;
        logic [4:0] off;
    } t_lk_req;

    // (a + b) mod 26 for a, b below 26
    function automatic logic [4:0] add_mod26(input logic [4:0] a, input logic [4:0] b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, ALPHA}) begin
            s = s - {1'b0, ALPHA};
        end
        return s[4:0];
    endfunction

    // (a - b) mod 26 for a, b below 26
    function automatic logic [4:0] sub_mod26(input logic [4:0] a, input logic [4:0] b);
        logic [5:0] s;
        if (a >= b) begin
            s = {1'b0, a} - {1'b0, b};
        end else begin
            s = {1'b0, a} + {1'b0, ALPHA} - {1'b0, b};
        end
        return s[4:0];
    endfunction

    // reduce a 5-bit value mod 26
    function automatic logic [4:0] red_mod26(input logic [4:0] a);
        logic [4:0] r;
        r = a;
        if (a >= ALPHA) begin
            r = a - ALPHA;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rotor_substitution_cipher.sv -----
// Load and start items are taken one per cycle while the block is idle. A
// character item keeps the block busy until its result enters the output register:
// a letter walks forward, reflector, back through the active modules' key tables,
// one key table lookup issued each cycle; a non-letter skips the walk.
// Reset (synchronous, active low) sets one module in use, forward reflector,
// and zeroes positions, periods and counters; key tables hold until written.
// ----------------------------------------------------------------------------
// rotor_substitution_cipher
// Rotor cipher over A..Z: a small sequencer walks a letter through the key
// tables of the active modules, then steps the module positions.
// ----------------------------------------------------------------------------
`default_nettype none

module rotor_substitution_cipher #(
    parameter int MAX_MODULES = rsc_pkg::MAX_MODULES_DEF,
    parameter int PERIOD_BITS = rsc_pkg::PERIOD_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [3:0]  i_cfg_data,
    // input items
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [2:0]  i_module_sel,
    input  wire logic [4:0]  i_plain_index,
    input  wire logic [4:0]  i_key_letter,
    input  wire logic [4:0]  i_start_position,
    input  wire logic [15:0] i_step_period,
    input  wire logic [7:0]  i_char_in,
    // result items
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_char_out
);

    localparam int MOD_W = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FWD  = 5'b00010,
        S_REFL = 5'b00100,
        S_BACK = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [3:0]             r_active;
    logic                   r_refl;
    logic [MOD_W-1:0]       r_mod;
    logic                   r_first;
    logic [4:0]             r_x;
    logic                   r_letter;
    logic [7:0]             r_char;
    logic                   r_out_valid;
    logic [7:0]             r_char_out;
    logic [4:0]             r_init [MAX_MODULES];
    logic [PERIOD_BITS-1:0] r_per  [MAX_MODULES];
    logic [4:0]             r_pos  [MAX_MODULES];
    logic [PERIOD_BITS-1:0] r_res  [MAX_MODULES];

    logic [MOD_W-1:0]       w_last;
    logic                   w_take;
    logic                   w_sel_ok;
    logic                   w_letter_in;
    logic                   w_out_free;
    logic                   w_done;
    logic [4:0]             w_x;
    rsc_pkg::t_cmd          w_cmd;
    rsc_pkg::t_key_wr       w_key_wr;
    rsc_pkg::t_lk_req       w_req;

    // last module index from the module count, clamped to 1..MAX_MODULES
    always_comb begin
        if (r_active == 4'd0) begin
            w_last = '0;
        end else if (32'(r_active) > MAX_MODULES) begin
            w_last = MOD_W'(MAX_MODULES - 1);
        end else begin
            w_last = MOD_W'(r_active - 4'd1);
        end
    end

    // input decode
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_take      = i_in_valid && o_in_ready;
    assign w_cmd       = rsc_pkg::t_cmd'(i_cmd);
    assign w_sel_ok    = (32'(i_module_sel) < MAX_MODULES);
    assign w_letter_in = (i_char_in >= rsc_pkg::CHAR_A) && (i_char_in <= rsc_pkg::CHAR_Z);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_done      = (r_state == S_FIN) && w_out_free;

    // key table write
    always_comb begin
        w_key_wr.valid = w_take && (w_cmd == rsc_pkg::CMD_KEY) && w_sel_ok
                         && (i_plain_index < rsc_pkg::ALPHA)
                         && (i_key_letter < rsc_pkg::ALPHA);
        w_key_wr.sel   = i_module_sel;
        w_key_wr.plain = i_plain_index;
        w_key_wr.key   = i_key_letter;
    end

    // lookup request for the current module
    always_comb begin
        w_req.issue = (r_state == S_FWD) || (r_state == S_REFL) || (r_state == S_BACK);
        w_req.inv   = ((r_state == S_REFL) && r_refl) || (r_state == S_BACK);
        w_req.first = r_first;
        w_req.x     = r_x;
        w_req.off   = r_pos[r_mod];
    end

    rsc_lookup #(
        .MAX_MODULES (MAX_MODULES)
    ) u_lookup (
        .i_clk    (i_clk),
        .i_key_wr (w_key_wr),
        .i_req    (w_req),
        .i_mod    (r_mod),
        .o_x      (w_x)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_take && (w_cmd == rsc_pkg::CMD_CHAR)) begin
                    if (!w_letter_in) begin
                        n_state = S_FIN;
                    end else if (w_last == '0) begin
                        n_state = S_REFL;
                    end else begin
                        n_state = S_FWD;
                    end
                end
            end
            S_FWD: begin
                if (r_mod == w_last - MOD_W'(1)) begin
                    n_state = S_REFL;
                end
            end
            S_REFL: begin
                n_state = (w_last == '0) ? S_FIN : S_BACK;
            end
            S_BACK: begin
                if (r_mod == '0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and per-module state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 4'd1;
            r_refl      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < MAX_MODULES; j++) begin
                r_init[j] <= '0;
                r_per[j]  <= '0;
                r_pos[j]  <= '0;
                r_res[j]  <= '0;
            end
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rsc_pkg::CFG_ACTIVE: r_active <= i_cfg_data;
                    rsc_pkg::CFG_REFL:   r_refl   <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // module settings and message start
            if (w_take && (w_cmd == rsc_pkg::CMD_SET) && w_sel_ok) begin
                r_init[MOD_W'(i_module_sel)] <= rsc_pkg::red_mod26(i_start_position);
                r_per[MOD_W'(i_module_sel)]  <= PERIOD_BITS'(i_step_period);
            end
            if (w_take && (w_cmd == rsc_pkg::CMD_START)) begin
                for (int j = 0; j < MAX_MODULES; j++) begin
                    r_pos[j] <= r_init[j];
                    r_res[j] <= '0;
                end
            end

            // counter and position stepping once the character is finished
            if (w_done) begin
                for (int j = 0; j < MAX_MODULES; j++) begin
                    if (j <= int'(w_last)) begin
                        if (r_per[j] == '0) begin
                            r_res[j] <= '0;
                        end else if ({1'b0, r_res[j]} + (PERIOD_BITS + 1)'(1)
                                     >= {1'b0, r_per[j]}) begin
                            r_res[j] <= '0;
                            if (r_letter) begin
                                r_pos[j] <= rsc_pkg::add_mod26(r_pos[j], 5'd1);
                            end
                        end else begin
                            r_res[j] <= r_res[j] + PERIOD_BITS'(1);
                        end
                    end
                end
            end

            // result register
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload and walk through the modules
    always_ff @(posedge i_clk) begin
        if (w_take && (w_cmd == rsc_pkg::CMD_CHAR)) begin
            r_letter <= w_letter_in;
            r_char   <= i_char_in;
            r_x      <= 5'(i_char_in - rsc_pkg::CHAR_A);
            r_first  <= 1'b1;
            r_mod    <= '0;
        end else if (w_req.issue) begin
            r_first <= 1'b0;
            if (r_state == S_FWD) begin
                r_mod <= r_mod + MOD_W'(1);
            end else if (r_state == S_REFL) begin
                r_mod <= w_last - MOD_W'(1);
            end else if (r_mod != '0) begin
                r_mod <= r_mod - MOD_W'(1);
            end
        end
        if (w_done) begin
            r_char_out <= r_letter ? (rsc_pkg::CHAR_A + {3'b000, w_x}) : r_char;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_char_out  = r_char_out;

`ifndef NO_ASSERTIONS
    // a letter starts the walk in a lookup state
    a_letter_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && (w_cmd == rsc_pkg::CMD_CHAR) && w_letter_in
        |=> (r_state == S_FWD) || (r_state == S_REFL))
        else $error("letter did not start a lookup walk");

    // the walk never addresses a module past the reflector
    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.issue |-> (r_mod <= w_last))
        else $error("lookup module index beyond last active module");

    // a finished character is presented and the block returns to idle
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> o_out_valid && (r_state == S_IDLE))
        else $error("finished character not presented");

    // the reflector lookup is followed by the back pass or the finish
    a_refl_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REFL) |=> (r_state == S_BACK) || (r_state == S_FIN))
        else $error("reflector not followed by back pass or finish");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/rsc_ram.sv -----
// ----------------------------------------------------------------------------
// rsc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rsc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 208,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rsc_lookup.sv -----
// ----------------------------------------------------------------------------
// rsc_lookup
// Shared table lookup unit: forward and inverse key tables with offset
// arithmetic, one lookup issued per cycle, result chained into the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module rsc_lookup #(
    parameter int MAX_MODULES = rsc_pkg::MAX_MODULES_DEF,
    localparam int MOD_W = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1
) (
    input  wire logic             i_clk,
    input  wire rsc_pkg::t_key_wr i_key_wr,
    input  wire rsc_pkg::t_lk_req i_req,
    input  wire logic [MOD_W-1:0] i_mod,
    output logic      [4:0]       o_x
);

    localparam int DEPTH  = MAX_MODULES * 26;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [ADDR_W-1:0] w_wr_base;
    logic [ADDR_W-1:0] w_fwd_waddr;
    logic [ADDR_W-1:0] w_inv_waddr;
    logic [ADDR_W-1:0] w_raddr;
    logic [4:0]        w_col;
    logic [4:0]        w_x_now;
    logic [4:0]        w_fwd_rd;
    logic [4:0]        w_inv_rd;
    logic [4:0]        w_raw;
    logic [4:0]        w_post;
    logic              r_prev_inv;
    logic [4:0]        r_prev_off;

    // key write addresses: forward at the plain index, inverse at the key letter
    assign w_wr_base   = ADDR_W'(i_key_wr.sel) * ADDR_W'(rsc_pkg::ALPHA);
    assign w_fwd_waddr = w_wr_base + ADDR_W'(i_key_wr.plain);
    assign w_inv_waddr = w_wr_base + ADDR_W'(i_key_wr.key);

    // finish the previous lookup: inverse results take the offset off
    assign w_raw  = r_prev_inv ? w_inv_rd : w_fwd_rd;
    assign w_post = r_prev_inv ? rsc_pkg::sub_mod26(w_raw, r_prev_off) : w_raw;
    assign o_x    = w_post;

    // next lookup address from the chained value
    assign w_x_now = i_req.first ? i_req.x : w_post;
    assign w_col   = i_req.inv ? w_x_now : rsc_pkg::add_mod26(w_x_now, i_req.off);
    assign w_raddr = ADDR_W'(i_mod) * ADDR_W'(rsc_pkg::ALPHA) + ADDR_W'(w_col);

    // remember how to finish the lookup in flight
    always_ff @(posedge i_clk) begin
        if (i_req.issue) begin
            r_prev_inv <= i_req.inv;
            r_prev_off <= i_req.off;
        end
    end

    rsc_ram #(
        .WIDTH (5),
        .DEPTH (DEPTH)
    ) u_fwd_ram (
        .i_clk   (i_clk),
        .i_we    (i_key_wr.valid),
        .i_waddr (w_fwd_waddr),
        .i_wdata (i_key_wr.key),
        .i_re    (i_req.issue && !i_req.inv),
        .i_raddr (w_raddr),
        .o_rdata (w_fwd_rd)
    );

    rsc_ram #(
        .WIDTH (5),
        .DEPTH (DEPTH)
    ) u_inv_ram (
        .i_clk   (i_clk),
        .i_we    (i_key_wr.valid),
        .i_waddr (w_inv_waddr),
        .i_wdata (i_key_wr.plain),
        .i_re    (i_req.issue && i_req.inv),
        .i_raddr (w_raddr),
        .o_rdata (w_inv_rd)
    );

endmodule

`default_nettype wire
